>>> rtl/core/slacm_pkg.sv
// ----------------------------------------------------------------------------
// slacm_pkg
// Shared types and constants of the set-associative cache model: operation
// codes, configuration register indexes and controller/datapath structs.
// ----------------------------------------------------------------------------
package slacm_pkg;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_STORE = 2'd1,
		OP_FETCH = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;

	localparam logic [2:0] CFG_SPLIT  = 3'd0;
	localparam logic [2:0] CFG_WALLOC = 3'd1;
	localparam logic [2:0] CFG_BLOCK  = 3'd2;
	localparam logic [2:0] CFG_WAYS   = 3'd3;
	localparam logic [2:0] CFG_USETS  = 3'd4;
	localparam logic [2:0] CFG_ISETS  = 3'd5;
	localparam logic [2:0] CFG_DSETS  = 3'd6;

	localparam logic [18:0] DATA_CB_MAX  = 19'h7FFFF;
	localparam logic [17:0] INSTR_CB_MAX = 18'h3FFFF;

	typedef struct packed {
		logic accept;
		logic look;
		logic update;
		logic fl_rd;
		logic fl_wr;
		logic fl_done;
		logic clr;
	} slacm_cmd_t;

	typedef struct packed {
		logic in_flush;
		logic out_free;
		logic row_last;
	} slacm_status_t;

endpackage

>>> rtl/core/set_assoc_lru_cache_model.sv
// An access is accepted in IDLE, reads its set row in READ and writes it back in UPDATE,
// which loads the result register and waits while the previous result is not taken.
// A new word is taken only back in IDLE. A flush walks every row, reading it in FL_RD
// and clearing its dirty bits in FL_WR; FL_DONE loads its result once the output is free.
// After reset a clearing pass over all 2 * MAX_SETS rows zeroes the line state;
// no word is accepted during it, configuration writes are taken as ever.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model
// Top level of the set-associative write-back cache model with LRU ranks.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_model import slacm_pkg::*; #(
	parameter int MAX_SETS  = 256,
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic        filled_empty,
	output logic        replaced,
	output logic        victim_dirty,
	output logic [6:0]  fetch_words,
	output logic [18:0] data_copyback_words,
	output logic [17:0] instr_copyback_words,
	output logic        was_instruction
);

	slacm_cmd_t    cmd;
	slacm_status_t status;

	slacm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	slacm_dp #(
		.MAX_SETS  (MAX_SETS),
		.MAX_WAYS  (MAX_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.status               (status),
		.cfg_write            (cfg_write),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.operation            (operation),
		.address              (address),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.hit                  (hit),
		.filled_empty         (filled_empty),
		.replaced             (replaced),
		.victim_dirty         (victim_dirty),
		.fetch_words          (fetch_words),
		.data_copyback_words  (data_copyback_words),
		.instr_copyback_words (instr_copyback_words),
		.was_instruction      (was_instruction)
	);

endmodule

>>> rtl/core/slacm_ram.sv
// ----------------------------------------------------------------------------
// slacm_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module slacm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/slacm_ctrl.sv
// ----------------------------------------------------------------------------
// slacm_ctrl
// Controller of the cache model: clearing pass after reset, access sequence
// (read set, update set) and flush walk over every row.
// ----------------------------------------------------------------------------
module slacm_ctrl import slacm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  slacm_status_t status,
	output slacm_cmd_t    cmd
);

	typedef enum logic [6:0] {
		S_CLEAR   = 7'b0000001,
		S_IDLE    = 7'b0000010,
		S_READ    = 7'b0000100,
		S_UPDATE  = 7'b0001000,
		S_FL_RD   = 7'b0010000,
		S_FL_WR   = 7'b0100000,
		S_FL_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.row_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = status.in_flush ? S_FL_RD : S_READ;
				end
			end
			S_READ: begin
				cmd.look = 1'b1;
				state_d  = S_UPDATE;
			end
			S_UPDATE: begin
				if (status.out_free) begin
					cmd.update = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_FL_RD: begin
				cmd.fl_rd = 1'b1;
				state_d   = S_FL_WR;
			end
			S_FL_WR: begin
				cmd.fl_wr = 1'b1;
				state_d   = status.row_last ? S_FL_DONE : S_FL_RD;
			end
			S_FL_DONE: begin
				if (status.out_free) begin
					cmd.fl_done = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/slacm_dp.sv
// ----------------------------------------------------------------------------
// slacm_dp
// Datapath of the cache model: configuration registers, tag and line-state
// memories, lookup, LRU rank update, flush counting and the result register.
// ----------------------------------------------------------------------------
module slacm_dp import slacm_pkg::*; #(
	parameter int MAX_SETS  = 256,
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  slacm_cmd_t    cmd,
	output slacm_status_t status,
	input  logic          cfg_write,
	input  logic [2:0]    cfg_index,
	input  logic [3:0]    cfg_data,
	input  logic [1:0]    operation,
	input  logic [31:0]   address,
	output logic          out_valid,
	input  logic          out_ready,
	output logic          hit,
	output logic          filled_empty,
	output logic          replaced,
	output logic          victim_dirty,
	output logic [6:0]    fetch_words,
	output logic [18:0]   data_copyback_words,
	output logic [17:0]   instr_copyback_words,
	output logic          was_instruction
);

	localparam int SL     = $clog2(MAX_SETS + 1) - 1;
	localparam int ROWS   = 2 * MAX_SETS;
	localparam int RAW    = $clog2(ROWS);
	localparam int RW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int META_W = MAX_WAYS * (2 + RW);
	localparam int TROW_W = MAX_WAYS * 32;
	localparam logic [RW-1:0] RANK_MAX = RW'(MAX_WAYS - 1);
	localparam logic [31:0] ADDR_MASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ADDR_BITS) - 64'd1);

	// Configuration registers.
	logic       split_q, walloc_q;
	logic [3:0] bbl_q, ways_q, usl_q, isl_q, dsl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_q  <= 1'b0;
			walloc_q <= 1'b1;
			bbl_q    <= 4'd4;
			ways_q   <= 4'd1;
			usl_q    <= 4'd8;
			isl_q    <= 4'd8;
			dsl_q    <= 4'd8;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SPLIT:  split_q  <= cfg_data[0];
				CFG_WALLOC: walloc_q <= cfg_data[0];
				CFG_BLOCK:  bbl_q    <= cfg_data;
				CFG_WAYS:   ways_q   <= cfg_data;
				CFG_USETS:  usl_q    <= cfg_data;
				CFG_ISETS:  isl_q    <= cfg_data;
				CFG_DSETS:  dsl_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [3:0] b_c;
	logic [4:0] ways_c;
	logic [6:0] words;

	assign b_c    = (bbl_q < 4'd2) ? 4'd2 : ((bbl_q > 4'd8) ? 4'd8 : bbl_q);
	assign ways_c = (ways_q == 4'd0) ? 5'd1 :
		((5'(ways_q) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(ways_q));
	assign words  = 7'd1 << (b_c - 4'd2);

	// Item registers.
	op_t             op_q;
	logic [31:0]     addr_q;
	logic [31:0]     tag_q;
	logic [RAW-1:0]  row_acc_q;
	logic [RAW-1:0]  row_q;
	logic [18:0]     dacc_q;
	logic [17:0]     iacc_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= op_t'(operation);
			addr_q <= address & ADDR_MASK;
		end
	end

	// Set and tag of the latched address.
	logic        half;
	logic [3:0]  s_raw, s_c;
	logic [31:0] set32, tag32;
	logic [RAW-1:0] row_calc;

	always_comb begin
		half  = split_q && (op_q == OP_FETCH);
		s_raw = split_q ? ((op_q == OP_FETCH) ? isl_q : dsl_q) : usl_q;
		s_c   = (32'(s_raw) > 32'(SL)) ? 4'(SL) : s_raw;
		set32 = (addr_q >> b_c) & ((32'd1 << s_c) - 32'd1);
		tag32 = addr_q >> (5'(b_c) + 5'(s_c));
		row_calc = (half ? RAW'(MAX_SETS) : RAW'(0)) + RAW'(set32);
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			tag_q     <= tag32;
			row_acc_q <= row_calc;
		end
	end

	// Memories.
	logic              meta_we, meta_re, tag_we;
	logic [RAW-1:0]    meta_waddr, meta_raddr;
	logic [META_W-1:0] meta_wdata, meta_rdata, meta_upd, meta_fl;
	logic [TROW_W-1:0] trow_rdata, trow_wdata;

	assign meta_we    = cmd.clr | cmd.fl_wr | cmd.update;
	assign meta_waddr = cmd.update ? row_acc_q : row_q;
	assign meta_wdata = cmd.clr ? '0 : (cmd.fl_wr ? meta_fl : meta_upd);
	assign meta_re    = cmd.look | cmd.fl_rd;
	assign meta_raddr = cmd.look ? row_calc : row_q;

	slacm_ram #(.WIDTH(META_W), .DEPTH(ROWS)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.re    (meta_re),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	slacm_ram #(.WIDTH(TROW_W), .DEPTH(ROWS)) u_tag (
		.clk   (clk),
		.we    (tag_we),
		.waddr (row_acc_q),
		.wdata (trow_wdata),
		.re    (cmd.look),
		.raddr (row_calc),
		.rdata (trow_rdata)
	);

	// Lookup and LRU update of one set.
	logic [MAX_WAYS-1:0] vld, drt, in_use, nvld, ndrt;
	logic [RW-1:0]       rnk [MAX_WAYS];
	logic [RW-1:0]       nrnk [MAX_WAYS];
	logic                hit_any, empty_any, noalloc, age_all, is_store;
	logic [RW-1:0]       hit_w, empty_w, vic_w, sel_w, limit;

	always_comb begin
		is_store  = (op_q == OP_STORE);
		hit_any   = 1'b0;
		empty_any = 1'b0;
		hit_w     = '0;
		empty_w   = '0;
		vic_w     = '0;
		trow_wdata = trow_rdata;
		for (int i = 0; i < MAX_WAYS; i++) begin
			vld[i]    = meta_rdata[i];
			drt[i]    = meta_rdata[MAX_WAYS + i];
			rnk[i]    = meta_rdata[2 * MAX_WAYS + i * RW +: RW];
			in_use[i] = (5'(i) < ways_c);
		end
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (in_use[i] && vld[i] && (trow_rdata[i * 32 +: 32] == tag_q)) begin
				hit_any = 1'b1;
				hit_w   = RW'(i);
			end
			if (in_use[i] && !vld[i]) begin
				empty_any = 1'b1;
				empty_w   = RW'(i);
			end
		end
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (in_use[i] && (rnk[i] > rnk[vic_w])) begin
				vic_w = RW'(i);
			end
		end
		sel_w   = hit_any ? hit_w : (empty_any ? empty_w : vic_w);
		noalloc = !hit_any && is_store && !walloc_q;
		age_all = !hit_any && empty_any;
		limit   = rnk[sel_w];
		nvld    = vld;
		ndrt    = drt;
		for (int i = 0; i < MAX_WAYS; i++) begin
			nrnk[i] = rnk[i];
			if (RW'(i) == sel_w) begin
				nrnk[i] = '0;
			end else if (in_use[i] && vld[i] && (age_all || (rnk[i] < limit)) &&
					(rnk[i] < RANK_MAX)) begin
				nrnk[i] = rnk[i] + RW'(1);
			end
		end
		if (hit_any) begin
			ndrt[sel_w] = drt[sel_w] | is_store;
		end else begin
			nvld[sel_w] = 1'b1;
			ndrt[sel_w] = is_store;
			trow_wdata[sel_w * 32 +: 32] = tag_q;
		end
		meta_upd[MAX_WAYS-1:0]            = nvld;
		meta_upd[2*MAX_WAYS-1:MAX_WAYS]   = ndrt;
		for (int i = 0; i < MAX_WAYS; i++) begin
			meta_upd[2 * MAX_WAYS + i * RW +: RW] = nrnk[i];
		end
		if (noalloc) begin
			meta_upd = meta_rdata;
		end
		meta_fl = meta_rdata;
		meta_fl[2*MAX_WAYS-1:MAX_WAYS] = '0;
	end

	assign tag_we = cmd.update && !hit_any && !noalloc;

	// Flush counting and row counter.
	logic [10:0] fl_words;
	logic [19:0] dsum;
	logic [18:0] isum;
	logic        fl_half;

	assign fl_words = 11'($countones(drt)) << (b_c - 4'd2);
	assign fl_half  = (32'(row_q) >= 32'(MAX_SETS));
	assign dsum     = 20'(dacc_q) + 20'(fl_words);
	assign isum     = 19'(iacc_q) + 19'(fl_words);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			dacc_q <= '0;
			iacc_q <= '0;
		end else if (cmd.fl_wr) begin
			if (fl_half) begin
				iacc_q <= (isum > 19'(INSTR_CB_MAX)) ? INSTR_CB_MAX : isum[17:0];
			end else begin
				dacc_q <= (dsum > 20'(DATA_CB_MAX)) ? DATA_CB_MAX : dsum[18:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.clr || cmd.fl_wr) begin
			row_q <= status.row_last ? '0 : row_q + RAW'(1);
		end
	end

	// Result register.
	logic        out_valid_q;
	logic        hit_q, fe_q, rep_q, vd_q, wi_q;
	logic [6:0]  fw_q;
	logic [18:0] dcb_q;
	logic [17:0] icb_q;
	logic        vdirty;

	assign vdirty = !hit_any && !empty_any && !noalloc && drt[sel_w];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update || cmd.fl_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q <= hit_any;
			fe_q  <= !hit_any && !noalloc && empty_any;
			rep_q <= !hit_any && !noalloc && !empty_any;
			vd_q  <= vdirty;
			fw_q  <= (!hit_any && !noalloc) ? words : 7'd0;
			dcb_q <= noalloc ? 19'd1 :
				((vdirty && (op_q != OP_FETCH)) ? 19'(words) : 19'd0);
			icb_q <= (vdirty && (op_q == OP_FETCH)) ? 18'(words) : 18'd0;
			wi_q  <= (op_q == OP_FETCH);
		end else if (cmd.fl_done) begin
			hit_q <= 1'b0;
			fe_q  <= 1'b0;
			rep_q <= 1'b0;
			vd_q  <= 1'b0;
			fw_q  <= 7'd0;
			dcb_q <= dacc_q;
			icb_q <= iacc_q;
			wi_q  <= 1'b0;
		end
	end

	assign out_valid            = out_valid_q;
	assign hit                  = hit_q;
	assign filled_empty         = fe_q;
	assign replaced             = rep_q;
	assign victim_dirty         = vd_q;
	assign fetch_words          = fw_q;
	assign data_copyback_words  = dcb_q;
	assign instr_copyback_words = icb_q;
	assign was_instruction      = wi_q;

	assign status.in_flush = (op_t'(operation) == OP_FLUSH);
	assign status.out_free = !out_valid_q || out_ready;
	assign status.row_last = (row_q == RAW'(ROWS - 1));

endmodule

>>> tb/sv/cache_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cache_checker
// Watches the request and result channels of the cache model, keeps its own
// copy of the tag, valid, dirty and rank state, predicts each result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module cache_checker import slacm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        hit,
	input  logic        filled_empty,
	input  logic        replaced,
	input  logic        victim_dirty,
	input  logic [6:0]  fetch_words,
	input  logic [18:0] data_copyback_words,
	input  logic [17:0] instr_copyback_words,
	input  logic        was_instruction,
	output int          errors,
	output int          pending,
	output int          results_seen
);

	localparam int SETS  = 256;
	localparam int WAYS  = 8;
	localparam int LINES = 2 * SETS * WAYS;

	typedef struct packed {
		logic        hit;
		logic        filled_empty;
		logic        replaced;
		logic        victim_dirty;
		logic [6:0]  fetch_words;
		logic [18:0] data_cb;
		logic [17:0] instr_cb;
		logic        was_instr;
	} access_result_t;

	logic [31:0] tags  [LINES];
	logic        valid [LINES];
	logic        dirty [LINES];
	logic [2:0]  rank  [LINES];
	logic [3:0]  cfg   [7];
	access_result_t expected_results[$];

	function automatic void age_ways(int base, int ways, int w, int lim, bit all);
		for (int i = 0; i < ways; i++) begin
			if (i != w && valid[base + i] && (all || rank[base + i] < lim)) begin
				if (rank[base + i] < WAYS - 1)
					rank[base + i]++;
			end
		end
		rank[base + w] = 0;
	endfunction

	function automatic access_result_t predict_access(op_t op, logic [31:0] addr);
		access_result_t r;
		int b, s, ways, words, half, set, base, w;
		longint cbd, cbi;
		logic [31:0] tg;
		bit found;
		r = '0;
		found = 0;
		b = cfg[CFG_BLOCK] < 2 ? 2 : (cfg[CFG_BLOCK] > 8 ? 8 : cfg[CFG_BLOCK]);
		words = 1 << (b - 2);
		ways = cfg[CFG_WAYS] == 0 ? 1 : (cfg[CFG_WAYS] > WAYS ? WAYS : cfg[CFG_WAYS]);
		if (op == OP_FLUSH) begin
			cbd = 0;
			cbi = 0;
			for (int i = 0; i < LINES; i++) begin
				if (dirty[i]) begin
					if (i < SETS * WAYS) cbd += words;
					else cbi += words;
					dirty[i] = 0;
				end
			end
			r.data_cb = cbd > DATA_CB_MAX ? DATA_CB_MAX : cbd[18:0];
			r.instr_cb = cbi > INSTR_CB_MAX ? INSTR_CB_MAX : cbi[17:0];
			return r;
		end
		if (cfg[CFG_SPLIT]) begin
			half = op == OP_FETCH;
			s = op == OP_FETCH ? cfg[CFG_ISETS] : cfg[CFG_DSETS];
		end else begin
			half = 0;
			s = cfg[CFG_USETS];
		end
		if (s > 8) s = 8;
		set = (addr >> b) & ((1 << s) - 1);
		tg = addr >> (b + s);
		base = (half * SETS + set) * WAYS;
		r.was_instr = op == OP_FETCH;
		for (w = 0; w < ways; w++) begin
			if (valid[base + w] && tags[base + w] == tg) begin
				found = 1;
				break;
			end
		end
		if (found) begin
			r.hit = 1;
			if (op == OP_STORE) dirty[base + w] = 1;
			age_ways(base, ways, w, rank[base + w], 0);
			return r;
		end
		if (op == OP_STORE && !cfg[CFG_WALLOC]) begin
			r.data_cb = 1;
			return r;
		end
		r.fetch_words = 7'(words);
		for (w = 0; w < ways; w++)
			if (!valid[base + w]) break;
		if (w < ways) begin
			r.filled_empty = 1;
			valid[base + w] = 1;
			tags[base + w] = tg;
			dirty[base + w] = op == OP_STORE;
			age_ways(base, ways, w, 0, 1);
			return r;
		end
		w = 0;
		for (int i = 1; i < ways; i++)
			if (rank[base + i] > rank[base + w]) w = i;
		r.replaced = 1;
		if (dirty[base + w]) begin
			r.victim_dirty = 1;
			if (op == OP_FETCH) r.instr_cb = 18'(words);
			else r.data_cb = 19'(words);
		end
		tags[base + w] = tg;
		dirty[base + w] = op == OP_STORE;
		age_ways(base, ways, w, rank[base + w], 0);
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		access_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				tags[i] = '0;
				valid[i] = 0;
				dirty[i] = 0;
				rank[i] = '0;
			end
			cfg[0] = 0; cfg[1] = 1; cfg[2] = 4; cfg[3] = 1;
			cfg[4] = 8; cfg[5] = 8; cfg[6] = 8;
			expected_results.delete();
			errors = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			if (cfg_write && cfg_index < 7) begin
				if (cfg_index <= CFG_WALLOC) cfg[cfg_index] = {3'b0, cfg_data[0]};
				else cfg[cfg_index] = cfg_data;
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					report_mismatch("queued results for a result word", 0, 1);
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
					if (filled_empty !== want.filled_empty)
						report_mismatch("filled_empty", filled_empty, want.filled_empty);
					if (replaced !== want.replaced)
						report_mismatch("replaced", replaced, want.replaced);
					if (victim_dirty !== want.victim_dirty)
						report_mismatch("victim_dirty", victim_dirty, want.victim_dirty);
					if (fetch_words !== want.fetch_words)
						report_mismatch("fetch_words", fetch_words, want.fetch_words);
					if (data_copyback_words !== want.data_cb)
						report_mismatch("data_copyback_words", data_copyback_words,
							want.data_cb);
					if (instr_copyback_words !== want.instr_cb)
						report_mismatch("instr_copyback_words", instr_copyback_words,
							want.instr_cb);
					if (was_instruction !== want.was_instr)
						report_mismatch("was_instruction", was_instruction,
							want.was_instr);
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(predict_access(op_t'(operation), address));
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives loads, stores, fetches and flushes into the cache model under a
// range of geometries and allocation policies, with random stalls on both
// channels, and gives the verdict from the checker's error and pending counts.
// ----------------------------------------------------------------------------
module testbench;
	import slacm_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_write = 0;
	logic [2:0]  cfg_index = '0;
	logic [3:0]  cfg_data = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  operation = '0;
	logic [31:0] address = '0;
	logic        out_valid;
	logic        out_ready = 0;
	logic        hit, filled_empty, replaced, victim_dirty, was_instruction;
	logic [6:0]  fetch_words;
	logic [18:0] data_copyback_words;
	logic [17:0] instr_copyback_words;
	int          errors, pending, results_seen;
	int          cycles = 0;
	int          words_sent = 0;
	int          flushes = 0;
	bit          quiet = 0;
	logic [31:0] hot_addr[16];

	always #5 clk = ~clk;

	set_assoc_lru_cache_model i_dut (.*);

	cache_checker i_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Result side: stalls in bursts, none once the run is in its last part.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			out_ready <= 1;
			n = $urandom_range(1, 40);
			repeat (n) @(posedge clk);
			if (!quiet && $urandom_range(0, 2) == 0) begin
				out_ready <= 0;
				n = $urandom_range(1, 19);
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [3:0] val);
		cfg_write <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic drain;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_word(op_t op, logic [31:0] addr);
		int n;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 0;
			n = $urandom_range(1, 19);
			repeat (n) @(posedge clk);
		end
		in_valid <= 1;
		operation <= op;
		address <= addr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		if (op == OP_FLUSH) flushes++;
	endtask

	task automatic send_random(int count, int flush_pct);
		op_t op;
		logic [31:0] a;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < flush_pct) op = OP_FLUSH;
			else op = op_t'($urandom_range(0, 2));
			if ($urandom_range(0, 3) != 0)
				a = hot_addr[$urandom_range(0, 15)] ^ ($urandom_range(0, 3) << 8);
			else
				a = $urandom;
			send_word(op, a);
		end
		in_valid <= 0;
	endtask

	task automatic set_geometry(logic sp, logic wa, logic [3:0] b, logic [3:0] w,
		logic [3:0] u, logic [3:0] ic, logic [3:0] dc);
		drain();
		write_reg(CFG_SPLIT, {3'b0, sp});
		write_reg(CFG_WALLOC, {3'b0, wa});
		write_reg(CFG_BLOCK, b);
		write_reg(CFG_WAYS, w);
		write_reg(CFG_USETS, u);
		write_reg(CFG_ISETS, ic);
		write_reg(CFG_DSETS, dc);
		cfg_write <= 0;
	endtask

	initial begin
		for (int i = 0; i < 16; i++) hot_addr[i] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: field extremes, every operation, evictions and flushes.
		send_word(OP_LOAD, 32'h0000_0000);
		send_word(OP_LOAD, 32'h0000_0000);
		send_word(OP_STORE, 32'hFFFF_FFFF);
		send_word(OP_FETCH, 32'hFFFF_FFFF);
		send_word(OP_STORE, 32'h0010_0000);
		send_word(OP_LOAD, 32'h0020_0000);
		send_word(OP_FLUSH, 32'hFFFF_FFFF);
		in_valid <= 0;
		set_geometry(1, 0, 2, 2, 0, 0, 0);
		send_word(OP_STORE, 32'h0000_1000);
		send_word(OP_LOAD, 32'h0000_2000);
		send_word(OP_STORE, 32'h0000_2000);
		send_word(OP_FETCH, 32'h0000_3000);
		send_word(OP_LOAD, 32'h0000_4000);
		send_word(OP_STORE, 32'h0000_5000);
		send_word(OP_LOAD, 32'h0000_6000);
		send_word(OP_FETCH, 32'h0000_3000);
		send_word(OP_FLUSH, 32'h0);
		in_valid <= 0;

		set_geometry(0, 1, 8, 8, 0, 3, 3);
		send_random(150, 2);
		set_geometry(1, 1, 2, 4, 8, 1, 2);
		send_random(150, 2);
		// Nothing more goes in until every result is back.
		drain();
		set_geometry(0, 0, 5, 1, 8, 0, 0);
		send_random(150, 2);
		set_geometry(1, 0, 15, 15, 15, 15, 15);
		send_random(100, 3);
		set_geometry(0, 1, 0, 0, 2, 8, 8);
		send_random(150, 2);
		set_geometry(1, 1, 3, 2, 4, 0, 8);
		send_random(150, 2);
		set_geometry(0, 1, 8, 8, 8, 8, 8);
		send_random(300, 1);
		// Store and fetch random addresses in both halves, then flush.
		set_geometry(1, 1, 8, 8, 0, 8, 8);
		for (int i = 0; i < 40; i++) send_word(op_t'(i % 2 ? OP_STORE : OP_FETCH), $urandom);
		send_word(OP_FLUSH, 0);
		in_valid <= 0;
		set_geometry(0, 1, 4, 3, 2, 2, 2);
		quiet = 1;
		send_random(200, 2);

		drain();
		repeat (2 * 256 * 2 + 20) @(posedge clk);
		$display("Sent %0d words (%0d flushes) over eleven geometries; %0d results checked.",
			words_sent, flushes, results_seen);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
